>>> design/swlr_pkg.sv
package swlr_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int WS_BITS       = 7;
    localparam int RES_BITS      = 32;
    localparam int FRAC_BITS     = 16;
    localparam int DEFAULT_DEPTH = 64;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] query_x;
    } t_in;

    typedef struct packed {
        logic signed [RES_BITS-1:0] slope;
        logic signed [RES_BITS-1:0] intercept;
        logic signed [RES_BITS-1:0] prediction;
        logic        [WS_BITS-1:0]  points_used;
        logic                       degenerate;
    } t_out;

endpackage

>>> design/sliding_window_linear_regression_core.sv
// Sliding-window least-squares line fit, Q16.16 results.
// Input channel (i_in_valid / o_in_ready, i_in_data): one (x, y, query_x) word
// per sample. Output channel (o_out_valid / i_out_ready, o_out_data): one word
// per sample with slope, intercept, prediction, points_used and degenerate.
// i_cfg_we / i_cfg_data write the window size and empty the window; write only
// while the block is idle.
// Steps per sample: accept, sum update, 11 products on the shared shift-add unit
// (MBW = 16 + clog2(DEPTH+1) multiplier bits), 3 quotients on the same unit (one
// quotient bit a cycle), output load. A degenerate fit skips the quotients.
// o_in_ready is high only between samples; one word at a time is processed.
// The output register holds a finished word while the next sample is taken;
// if the receiver stalls, the block waits at the end of that next sample.
// Reset (synchronous, active low) empties the window and sets the window size
// to 64; store contents are not cleared, unused entries never reach a result.
module sliding_window_linear_regression_core #(
    parameter int DEPTH = swlr_pkg::DEFAULT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  swlr_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output swlr_pkg::t_out              o_out_data,
    input  logic                        i_cfg_we,
    input  logic [swlr_pkg::WS_BITS-1:0] i_cfg_data
);

    localparam int SB  = swlr_pkg::SAMPLE_BITS;
    localparam int RB  = swlr_pkg::RES_BITS;
    localparam int FB  = swlr_pkg::FRAC_BITS;
    localparam int WB  = swlr_pkg::WS_BITS;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AB  = $clog2(DEPTH);
    localparam int SW  = SB + CW;
    localparam int QW  = 2 * SB + CW + 1;
    localparam int MBW = SB + CW;
    localparam int AW  = 3 * SB + 3 * CW + 4;
    localparam int UW  = AW + 1;
    localparam int QB  = RB + 1;
    localparam int DW  = AW + FB + 1;
    localparam int CPW = AW + QB;
    localparam int STW = $clog2(MBW + QB);
    localparam int WEW = (CW > WB) ? CW : WB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MSET = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DSET = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [2:0] A_OXD = 3'd0;
    localparam logic [2:0] A_X   = 3'd1;
    localparam logic [2:0] A_SXX = 3'd2;
    localparam logic [2:0] A_SXY = 3'd3;
    localparam logic [2:0] A_SX  = 3'd4;
    localparam logic [2:0] A_NUM = 3'd5;

    localparam logic [2:0] B_OX  = 3'd0;
    localparam logic [2:0] B_OY  = 3'd1;
    localparam logic [2:0] B_X   = 3'd2;
    localparam logic [2:0] B_Y   = 3'd3;
    localparam logic [2:0] B_CNT = 3'd4;
    localparam logic [2:0] B_SX  = 3'd5;
    localparam logic [2:0] B_SY  = 3'd6;
    localparam logic [2:0] B_QX  = 3'd7;

    localparam logic [2:0] LD_KEEP = 3'd0;
    localparam logic [2:0] LD_ZERO = 3'd1;
    localparam logic [2:0] LD_SXX  = 3'd2;
    localparam logic [2:0] LD_SXY  = 3'd3;
    localparam logic [2:0] LD_CST  = 3'd4;

    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_SXX  = 3'd1;
    localparam logic [2:0] D_SXY  = 3'd2;
    localparam logic [2:0] D_NUM  = 3'd3;
    localparam logic [2:0] D_DEN  = 3'd4;
    localparam logic [2:0] D_CST  = 3'd5;
    localparam logic [2:0] D_PRD  = 3'd6;

    localparam logic [3:0] OP_LAST = 4'd10;
    localparam logic [1:0] DSEL_LAST = 2'd2;

    typedef struct packed {
        logic [2:0] asel;
        logic [2:0] bsel;
        logic       sub;
        logic [2:0] ld;
        logic [2:0] dst;
    } t_mop;

    function automatic logic [AW-1:0] ext_sb(input logic [SB-1:0] v);
        return {{(AW-SB){v[SB-1]}}, v};
    endfunction

    function automatic logic [AW-1:0] ext_sw(input logic [SW-1:0] v);
        return {{(AW-SW){v[SW-1]}}, v};
    endfunction

    function automatic logic [AW-1:0] ext_qw(input logic [QW-1:0] v);
        return {{(AW-QW){v[QW-1]}}, v};
    endfunction

    function automatic logic [MBW-1:0] mb_sb(input logic [SB-1:0] v);
        return {{(MBW-SB){v[SB-1]}}, v};
    endfunction

    logic [2:0]    r_state;
    logic [WB-1:0] r_wsize;
    logic [AB-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sx, r_sy;
    logic [QW-1:0] r_sxx, r_sxy;
    logic [SB-1:0] r_x, r_y, r_qx, r_ox, r_oy;
    logic          r_drop;
    logic [3:0]    r_op;
    logic [STW-1:0] r_step;
    logic [AW-1:0] r_acc, r_mcand;
    logic [MBW-1:0] r_mplier;
    logic [AW-1:0] r_num, r_den, r_cst, r_prd, r_ad;
    logic [1:0]    r_dsel;
    logic [UW-1:0] r_rem;
    logic [QB-1:0] r_dvd, r_q;
    logic          r_neg, r_degen;
    logic [RB-1:0] r_res [0:2];
    swlr_pkg::t_out r_out;
    logic          r_ovalid;

    logic [SB-1:0] x_store [0:DEPTH-1];
    logic [SB-1:0] y_store [0:DEPTH-1];

    logic          accept;
    logic [WEW-1:0] ws_ext, w_eff;
    logic [CW:0]   widx_sum;
    logic [AB-1:0] widx;
    t_mop          mop;
    logic [AW-1:0] a_val, mul_acc;
    logic [MBW-1:0] b_val;
    logic [UW:0]   u_a, u_b, u_sum;
    logic          u_sub, ge;
    logic [UW-1:0] div_t;
    logic [AW-1:0] dnum, an, ad;
    logic          dneg;
    logic [DW-1:0] num2;
    logic          sat;
    logic [QB-1:0] qf;
    logic [RB-1:0] qres;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        ws_ext = WEW'(r_wsize);
        if (ws_ext == '0) begin
            w_eff = WEW'(1);
        end else if (ws_ext > WEW'(DEPTH)) begin
            w_eff = WEW'(DEPTH);
        end else begin
            w_eff = ws_ext;
        end
        // oldest + count wraps once at most; same slot with or without a drop
        widx_sum = (CW+1)'(r_oldest) + (CW+1)'(r_count);
        if (widx_sum >= (CW+1)'(DEPTH)) begin
            widx_sum = widx_sum - (CW+1)'(DEPTH);
        end
        widx = widx_sum[AB-1:0];
    end

    // product program
    always_comb begin
        mop = '{asel: A_X, bsel: B_X, sub: 1'b0, ld: LD_KEEP, dst: D_NONE};
        unique case (r_op)
            4'd0:    mop = '{A_OXD, B_OX,  1'b1, LD_SXX,  D_NONE};
            4'd1:    mop = '{A_X,   B_X,   1'b0, LD_KEEP, D_SXX};
            4'd2:    mop = '{A_OXD, B_OY,  1'b1, LD_SXY,  D_NONE};
            4'd3:    mop = '{A_X,   B_Y,   1'b0, LD_KEEP, D_SXY};
            4'd4:    mop = '{A_SXY, B_CNT, 1'b0, LD_ZERO, D_NONE};
            4'd5:    mop = '{A_SX,  B_SY,  1'b1, LD_KEEP, D_NUM};
            4'd6:    mop = '{A_SXX, B_CNT, 1'b0, LD_ZERO, D_NONE};
            4'd7:    mop = '{A_SX,  B_SX,  1'b1, LD_KEEP, D_DEN};
            4'd8:    mop = '{A_SXX, B_SY,  1'b0, LD_ZERO, D_NONE};
            4'd9:    mop = '{A_SXY, B_SX,  1'b1, LD_KEEP, D_CST};
            4'd10:   mop = '{A_NUM, B_QX,  1'b0, LD_CST,  D_PRD};
            default: mop = '{A_X,   B_X,   1'b0, LD_KEEP, D_NONE};
        endcase
    end

    always_comb begin
        unique case (mop.asel)
            A_OXD:   a_val = r_drop ? ext_sb(r_ox) : '0;
            A_X:     a_val = ext_sb(r_x);
            A_SXX:   a_val = ext_qw(r_sxx);
            A_SXY:   a_val = ext_qw(r_sxy);
            A_SX:    a_val = ext_sw(r_sx);
            A_NUM:   a_val = r_num;
            default: a_val = '0;
        endcase
        unique case (mop.bsel)
            B_OX:    b_val = mb_sb(r_ox);
            B_OY:    b_val = mb_sb(r_oy);
            B_X:     b_val = mb_sb(r_x);
            B_Y:     b_val = mb_sb(r_y);
            B_CNT:   b_val = MBW'(r_count);
            B_SX:    b_val = r_sx;
            B_SY:    b_val = r_sy;
            B_QX:    b_val = mb_sb(r_qx);
        endcase
    end

    // quotient setup
    always_comb begin
        unique case (r_dsel)
            2'd0:    dnum = r_num;
            2'd1:    dnum = r_cst;
            default: dnum = r_prd;
        endcase
        dneg = dnum[AW-1] ^ r_den[AW-1];
        an   = dnum[AW-1] ? (AW'(0) - dnum) : dnum;
        ad   = r_den[AW-1] ? (AW'(0) - r_den) : r_den;
        num2 = {an, {FB{1'b0}}} + DW'(ad >> 1);
        // quotient of 2^33 or more saturates either way
        sat  = CPW'(num2) >= {ad, {QB{1'b0}}};
    end

    // shared add/subtract unit
    always_comb begin
        div_t = {r_rem[UW-2:0], r_dvd[QB-1]};
        if (r_state == S_DIV) begin
            u_a   = {1'b0, div_t};
            u_b   = (UW+1)'(r_ad);
            u_sub = 1'b1;
        end else begin
            u_a   = {{(UW+1-AW){r_acc[AW-1]}}, r_acc};
            u_b   = {{(UW+1-AW){r_mcand[AW-1]}}, r_mcand};
            // top multiplier bit carries negative weight
            u_sub = mop.sub ^ (r_step == STW'(MBW - 1));
        end
        u_sum   = u_a + (u_sub ? ~u_b : u_b) + (UW+1)'(u_sub);
        ge      = ~u_sum[UW];
        mul_acc = r_mplier[0] ? u_sum[AW-1:0] : r_acc;
        qf      = {r_q[QB-2:0], ge};
        if (r_neg) begin
            qres = (qf > QB'(33'h080000000)) ? 32'h80000000 : (RB'(0) - qf[RB-1:0]);
        end else begin
            qres = (qf > QB'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : qf[RB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            x_store[widx] <= i_in_data.sample_x;
            y_store[widx] <= i_in_data.sample_y;
            r_ox          <= x_store[r_oldest];
            r_oy          <= y_store[r_oldest];
            r_x           <= i_in_data.sample_x;
            r_y           <= i_in_data.sample_y;
            r_qx          <= i_in_data.query_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wsize  <= WB'(64);
            r_oldest <= '0;
            r_count  <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
            r_drop   <= 1'b0;
            r_op     <= '0;
            r_step   <= '0;
            r_dsel   <= '0;
            r_degen  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_OUT reloads the valid itself when the held word leaves
            if (r_ovalid && i_out_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_wsize  <= i_cfg_data;
                r_oldest <= '0;
                r_count  <= '0;
                r_sx     <= '0;
                r_sy     <= '0;
                r_sxx    <= '0;
                r_sxy    <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_drop  <= (WEW'(r_count) >= w_eff);
                        r_degen <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_sx <= r_sx - (r_drop ? SW'(signed'(r_ox)) : '0) + SW'(signed'(r_x));
                    r_sy <= r_sy - (r_drop ? SW'(signed'(r_oy)) : '0) + SW'(signed'(r_y));
                    if (r_drop) begin
                        r_oldest <= (r_oldest == AB'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_op    <= '0;
                    r_state <= S_MSET;
                end
                S_MSET: begin
                    r_mcand  <= a_val;
                    r_mplier <= b_val;
                    r_step   <= '0;
                    unique case (mop.ld)
                        LD_ZERO: r_acc <= '0;
                        LD_SXX:  r_acc <= ext_qw(r_sxx);
                        LD_SXY:  r_acc <= ext_qw(r_sxy);
                        LD_CST:  r_acc <= r_cst;
                        default: r_acc <= r_acc;
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc    <= mul_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_step   <= r_step + 1'b1;
                    if (r_step == STW'(MBW - 1)) begin
                        unique case (mop.dst)
                            D_SXX: r_sxx <= mul_acc[QW-1:0];
                            D_SXY: r_sxy <= mul_acc[QW-1:0];
                            // single point: line through the origin
                            D_NUM: r_num <= (r_count == CW'(1)) ? ext_sw(r_sy) : mul_acc;
                            D_DEN: r_den <= (r_count == CW'(1)) ? ext_sw(r_sx) : mul_acc;
                            D_CST: r_cst <= mul_acc;
                            D_PRD: r_prd <= mul_acc;
                            default: ;
                        endcase
                        if (r_op == OP_LAST) begin
                            r_dsel  <= '0;
                            r_state <= S_DSET;
                        end else begin
                            r_op    <= r_op + 1'b1;
                            r_state <= S_MSET;
                        end
                    end
                end
                S_DSET: begin
                    if (r_den == '0) begin
                        r_degen  <= 1'b1;
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_state  <= S_OUT;
                    end else if (sat) begin
                        r_res[r_dsel] <= dneg ? 32'h80000000 : 32'h7FFFFFFF;
                        if (r_dsel == DSEL_LAST) begin
                            r_state <= S_OUT;
                        end else begin
                            r_dsel <= r_dsel + 1'b1;
                        end
                    end else begin
                        r_rem   <= UW'(num2[DW-1:QB]);
                        r_dvd   <= num2[QB-1:0];
                        r_q     <= '0;
                        r_ad    <= ad;
                        r_neg   <= dneg;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? u_sum[UW-1:0] : div_t;
                    r_q    <= qf;
                    r_dvd  <= r_dvd << 1;
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(QB - 1)) begin
                        r_res[r_dsel] <= qres;
                        if (r_dsel == DSEL_LAST) begin
                            r_state <= S_OUT;
                        end else begin
                            r_dsel  <= r_dsel + 1'b1;
                            r_state <= S_DSET;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
            r_out.slope       <= r_res[0];
            r_out.intercept   <= r_res[1];
            r_out.prediction  <= r_res[2];
            r_out.points_used <= WB'(r_count);
            r_out.degenerate  <= r_degen;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("window count above depth");

    a_oldest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= AB'(DEPTH - 1))
        else $error("oldest index out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input ready right after a word was taken");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
        (o_out_data.slope == '0 && o_out_data.intercept == '0 &&
         o_out_data.prediction == '0))
        else $error("degenerate word with nonzero results");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ad != '0))
        else $error("divide with zero divisor");

endmodule
